// ===== hdl/ovpk_pkg.sv =====
// ----------------------------------------------------------------------------
// ovpk_pkg
// Shared types and constants of the pose fusion filter: beat payloads,
// configuration, controller commands and datapath status.
// ----------------------------------------------------------------------------
package ovpk_pkg;

   // Heading format is rad Q.13, so pi and 2*pi in that format.
   localparam int HEAD_PI  = 25736;
   localparam int HEAD_2PI = 51472;

   localparam logic [31:0] VAR_HEAD_RESET   = 32'd13;
   localparam logic [15:0] NOISE_GAIN_RESET = 16'd24576;
   localparam logic [15:0] MIN_POS_RESET    = 16'd1280;
   localparam logic [13:0] MIN_HEAD_RESET   = 14'd328;

   // Quotients of the blend and variance divisions fit in 33 bits.
   localparam int DIV_STEPS = 33;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] FUNC_FUSE = 2'd1;
   localparam logic [1:0] FUNC_LOAD = 2'd2;

   localparam logic [1:0] REG_NOISE_GAIN = 2'd0;
   localparam logic [1:0] REG_MIN_POS    = 2'd1;
   localparam logic [1:0] REG_MIN_HEAD   = 2'd2;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_H
   } axis_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_CAP,
      OP_STEP,
      OP_SQ,
      OP_NHI,
      OP_NLO,
      OP_NSUM,
      OP_NVAR,
      OP_FPREP,
      OP_FMUL1,
      OP_FDIV1,
      OP_FEST,
      OP_FMUL2,
      OP_FDIV2,
      OP_FVAR,
      OP_LOAD,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [15:0] delta_heading;
      logic signed [31:0] vis_x;
      logic signed [31:0] vis_y;
      logic signed [15:0] vis_heading;
      logic [31:0]        meas_var_x;
      logic [31:0]        meas_var_y;
      logic [31:0]        meas_var_heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] pose_heading;
      logic [31:0]        est_var_x;
      logic [31:0]        est_var_y;
      logic [31:0]        est_var_heading;
   } rsp_type;

   typedef struct packed {
      logic [15:0] noise_gain;
      logic [15:0] min_pos_step;
      logic [13:0] min_heading_step;
   } cfg_type;

   typedef struct packed {
      op_type   op;
      axis_type axis;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       sum_zero;
      logic       div_busy;
   } stat_type;

endpackage

// ===== hdl/odometry_vision_pose_kalman_top.sv =====
// ----------------------------------------------------------------------------
// odometry_vision_pose_kalman_top
// Scalar Kalman pose fusion over x, y and heading: odometry prediction,
// optional visual fusion or pose load, with an APB register port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  req       in         req_valid/ready  ovpk_pkg::req_type, one item a beat
//  rsp       out        rsp_valid/ready  ovpk_pkg::rsp_type, one result a beat
//  csr       in/out     psel/penable     three registers at 0x0, 0x4, 0x8
//
//  A predict item presents its result after the odometry step and the per-axis
//  noise update, and a load item after a further load step; a fuse item instead
//  runs the divider twice on each axis with a nonzero variance sum, waiting each time.
//  Reset is synchronous; it restores the registers and the filter state.
//  A waiting result does not block the next accepted beat until that beat's
//  own result is ready; then the block waits for rsp_ready.
// ----------------------------------------------------------------------------
module odometry_vision_pose_kalman_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ovpk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ovpk_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [15:0]        noise_gain_ff, noise_gain_in;
   logic [15:0]        min_pos_ff, min_pos_in;
   logic [13:0]        min_head_ff, min_head_in;
   ovpk_pkg::cfg_type  cfg;
   ovpk_pkg::cmd_type  cmd;
   ovpk_pkg::stat_type stat;

   always_comb begin
      noise_gain_in = noise_gain_ff;
      min_pos_in    = min_pos_ff;
      min_head_in   = min_head_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            ovpk_pkg::REG_NOISE_GAIN: noise_gain_in = pwdata[15:0];
            ovpk_pkg::REG_MIN_POS:    min_pos_in    = pwdata[15:0];
            ovpk_pkg::REG_MIN_HEAD:   min_head_in   = pwdata[13:0];
            default: begin
            end
         endcase
      end
      unique case (paddr[3:2])
         ovpk_pkg::REG_NOISE_GAIN: prdata = {16'd0, noise_gain_ff};
         ovpk_pkg::REG_MIN_POS:    prdata = {16'd0, min_pos_ff};
         ovpk_pkg::REG_MIN_HEAD:   prdata = {18'd0, min_head_ff};
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_gain_ff <= ovpk_pkg::NOISE_GAIN_RESET;
         min_pos_ff    <= ovpk_pkg::MIN_POS_RESET;
         min_head_ff   <= ovpk_pkg::MIN_HEAD_RESET;
      end else begin
         noise_gain_ff <= noise_gain_in;
         min_pos_ff    <= min_pos_in;
         min_head_ff   <= min_head_in;
      end
   end

   assign pready               = 1'b1;
   assign cfg.noise_gain       = noise_gain_ff;
   assign cfg.min_pos_step     = min_pos_ff;
   assign cfg.min_heading_step = min_head_ff;

   ovpk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ovpk_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .cfg      (cfg),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/ovpk_div.sv =====
// ----------------------------------------------------------------------------
// ovpk_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in DIV_STEPS bits, so the upper numerator half starts
// as the partial remainder.
// ----------------------------------------------------------------------------
module ovpk_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] num,
   input  logic [32:0] den,
   output logic [32:0] quo,
   output logic        busy
);

   logic [32:0]                    rem_ff, rem_in;
   logic [32:0]                    quo_ff, quo_in;
   logic [32:0]                    den_ff, den_in;
   logic [ovpk_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;

   logic [33:0] cand;
   logic [33:0] diff;
   logic        ge;

   always_comb begin
      cand = {rem_ff, quo_ff[32]};
      diff = cand - {1'b0, den_ff};
      ge   = (cand >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = num[65:33];
         quo_in  = num[32:0];
         den_in  = den;
         cnt_in  = ovpk_pkg::DIV_CNT_W'(ovpk_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[32:0] : cand[32:0];
         quo_in = {quo_ff[31:0], ge};
         cnt_in = cnt_ff - ovpk_pkg::DIV_CNT_W'(1);
         if (cnt_ff == ovpk_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign quo  = quo_ff;
   assign busy = busy_ff;

endmodule

// ===== hdl/ovpk_datapath.sv =====
// ----------------------------------------------------------------------------
// ovpk_datapath
// Filter state, one shared 32x32 multiplier, the noise and blend arithmetic
// and the divider. Every cycle does what the controller's command names.
// ----------------------------------------------------------------------------
module ovpk_datapath (
   input  logic               clock,
   input  logic               reset,
   input  ovpk_pkg::cmd_type  cmd,
   input  ovpk_pkg::req_type  req_data,
   input  ovpk_pkg::cfg_type  cfg,
   output ovpk_pkg::stat_type stat,
   output ovpk_pkg::rsp_type  rsp_data
);

   // Wraps a heading that lies within one turn of the range back into it.
   function automatic logic signed [15:0] wrap_head(input logic signed [18:0] v);
      logic signed [18:0] r;
      if (v >= 19'(ovpk_pkg::HEAD_PI)) begin
         r = v - 19'(ovpk_pkg::HEAD_2PI);
      end else if (v < -19'(ovpk_pkg::HEAD_PI)) begin
         r = v + 19'(ovpk_pkg::HEAD_2PI);
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

   ovpk_pkg::req_type  req_ff;
   ovpk_pkg::rsp_type  rsp_ff;
   logic signed [31:0] est_x_ff, est_y_ff;
   logic signed [15:0] est_h_ff;
   logic [31:0]        var_x_ff, var_y_ff, var_h_ff;
   logic [63:0]        prod_ff;
   logic [47:0]        nhi_ff, nlo_ff;
   logic [31:0]        noise_ff;
   logic signed [33:0] fe_ff;
   logic [32:0]        dmag_ff;
   logic               dneg_ff;
   logic [32:0]        sum_ff;

   logic [31:0]        d_mag, d_floor, s_val, v1, v2;
   logic [15:0]        dh_mag;
   logic signed [33:0] e_sel, m_sel, diff;
   logic signed [33:0] hm, he;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [79:0]        wide, wide_sh;
   logic [31:0]        noise_sat;
   logic [32:0]        vsum;
   logic [31:0]        vnew;
   logic signed [32:0] sx, sy;
   logic signed [16:0] sh;
   logic [65:0]        num;
   logic               div_start;
   logic [32:0]        quo;
   logic               div_busy;
   logic signed [34:0] r35;
   logic signed [31:0] r_sat;

   // Per-axis operand selection.
   always_comb begin
      dh_mag = req_ff.delta_heading[15] ? (~req_ff.delta_heading + 16'd1)
                                        : req_ff.delta_heading;
      hm = 34'(req_ff.vis_heading);
      if (hm >= 34'(ovpk_pkg::HEAD_PI)) begin
         hm = hm - 34'(ovpk_pkg::HEAD_2PI);
      end else if (hm < -34'(ovpk_pkg::HEAD_PI)) begin
         hm = hm + 34'(ovpk_pkg::HEAD_2PI);
      end
      he = 34'(est_h_ff);
      if (he - hm > 34'(ovpk_pkg::HEAD_PI)) begin
         hm = hm + 34'(ovpk_pkg::HEAD_2PI);
      end else if (hm - he > 34'(ovpk_pkg::HEAD_PI)) begin
         he = he + 34'(ovpk_pkg::HEAD_2PI);
      end
      case (cmd.axis)
         ovpk_pkg::AXIS_X: begin
            d_mag   = req_ff.delta_x[31] ? (~req_ff.delta_x + 32'd1) : req_ff.delta_x;
            d_floor = {16'd0, cfg.min_pos_step};
            v1      = var_x_ff;
            v2      = req_ff.meas_var_x;
            e_sel   = 34'(est_x_ff);
            m_sel   = 34'(req_ff.vis_x);
         end
         ovpk_pkg::AXIS_Y: begin
            d_mag   = req_ff.delta_y[31] ? (~req_ff.delta_y + 32'd1) : req_ff.delta_y;
            d_floor = {16'd0, cfg.min_pos_step};
            v1      = var_y_ff;
            v2      = req_ff.meas_var_y;
            e_sel   = 34'(est_y_ff);
            m_sel   = 34'(req_ff.vis_y);
         end
         default: begin
            d_mag   = {16'd0, dh_mag};
            d_floor = {18'd0, cfg.min_heading_step};
            v1      = var_h_ff;
            v2      = req_ff.meas_var_heading;
            e_sel   = he;
            m_sel   = hm;
         end
      endcase
      s_val = (d_mag < d_floor) ? d_floor : d_mag;
      diff  = m_sel - e_sel;
   end

   // Shared multiplier.
   always_comb begin
      case (cmd.op)
         ovpk_pkg::OP_SQ: begin
            mul_a = s_val;
            mul_b = s_val;
         end
         ovpk_pkg::OP_NHI: begin
            mul_a = prod_ff[63:32];
            mul_b = {16'd0, cfg.noise_gain};
         end
         ovpk_pkg::OP_NLO: begin
            mul_a = prod_ff[31:0];
            mul_b = {16'd0, cfg.noise_gain};
         end
         ovpk_pkg::OP_FMUL1: begin
            mul_a = dmag_ff[31:0];
            mul_b = v1;
         end
         ovpk_pkg::OP_FMUL2: begin
            mul_a = v1;
            mul_b = v2;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      // Noise is gain * s^2 scaled down by 2^24 for positions, 2^34 for heading.
      wide      = {nhi_ff, 32'd0} + {32'd0, nlo_ff};
      wide_sh   = (cmd.axis == ovpk_pkg::AXIS_H) ? (wide >> 34) : (wide >> 24);
      noise_sat = (wide_sh[79:32] != '0) ? 32'hFFFF_FFFF : wide_sh[31:0];
      vsum      = {1'b0, v1} + {1'b0, noise_ff};
      vnew      = vsum[32] ? 32'hFFFF_FFFF : vsum[31:0];

      sx = 33'(est_x_ff) + 33'(req_ff.delta_x);
      sy = 33'(est_y_ff) + 33'(req_ff.delta_y);
      sh = 17'(est_h_ff) + 17'(req_ff.delta_heading);

      if (cmd.op == ovpk_pkg::OP_FDIV1) begin
         num = {2'b0, prod_ff} + (dmag_ff[32] ? {2'b0, v1, 32'd0} : 66'd0)
             + {34'd0, sum_ff[32:1]};
      end else begin
         num = {2'b0, prod_ff} + {34'd0, sum_ff[32:1]};
      end
      div_start = (cmd.op == ovpk_pkg::OP_FDIV1) || (cmd.op == ovpk_pkg::OP_FDIV2);

      // Blended estimate moves toward the measurement by the rounded quotient.
      r35 = dneg_ff ? (35'(fe_ff) - 35'(quo)) : (35'(fe_ff) + 35'(quo));
      if (r35[34:31] == 4'b0000 || r35[34:31] == 4'b1111) begin
         r_sat = r35[31:0];
      end else begin
         r_sat = r35[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   end

   ovpk_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (sum_ff),
      .quo   (quo),
      .busy  (div_busy)
   );

   always_ff @(posedge clock) begin
      if (cmd.op == ovpk_pkg::OP_CAP) begin
         req_ff <= req_data;
      end
      if (cmd.op == ovpk_pkg::OP_SQ || cmd.op == ovpk_pkg::OP_FMUL1
          || cmd.op == ovpk_pkg::OP_FMUL2) begin
         prod_ff <= mul_p;
      end
      if (cmd.op == ovpk_pkg::OP_NHI) begin
         nhi_ff <= mul_p[47:0];
      end
      if (cmd.op == ovpk_pkg::OP_NLO) begin
         nlo_ff <= mul_p[47:0];
      end
      if (cmd.op == ovpk_pkg::OP_NSUM) begin
         noise_ff <= noise_sat;
      end
      if (cmd.op == ovpk_pkg::OP_FPREP) begin
         fe_ff   <= e_sel;
         dmag_ff <= diff[33] ? 33'(-diff) : diff[32:0];
         dneg_ff <= diff[33];
         sum_ff  <= {1'b0, v1} + {1'b0, v2};
      end
      if (cmd.op == ovpk_pkg::OP_OUT) begin
         rsp_ff.pose_x          <= est_x_ff;
         rsp_ff.pose_y          <= est_y_ff;
         rsp_ff.pose_heading    <= est_h_ff;
         rsp_ff.est_var_x       <= var_x_ff;
         rsp_ff.est_var_y       <= var_y_ff;
         rsp_ff.est_var_heading <= var_h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_x_ff <= '0;
         est_y_ff <= '0;
         est_h_ff <= '0;
         var_x_ff <= '0;
         var_y_ff <= '0;
         var_h_ff <= ovpk_pkg::VAR_HEAD_RESET;
      end else begin
         case (cmd.op)
            ovpk_pkg::OP_STEP: begin
               est_x_ff <= (sx[32] != sx[31]) ? (sx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                              : sx[31:0];
               est_y_ff <= (sy[32] != sy[31]) ? (sy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                              : sy[31:0];
               est_h_ff <= wrap_head(19'(sh));
            end
            ovpk_pkg::OP_NVAR, ovpk_pkg::OP_FVAR: begin
               case (cmd.axis)
                  ovpk_pkg::AXIS_X: var_x_ff <= (cmd.op == ovpk_pkg::OP_NVAR) ? vnew : quo[31:0];
                  ovpk_pkg::AXIS_Y: var_y_ff <= (cmd.op == ovpk_pkg::OP_NVAR) ? vnew : quo[31:0];
                  default:          var_h_ff <= (cmd.op == ovpk_pkg::OP_NVAR) ? vnew : quo[31:0];
               endcase
            end
            ovpk_pkg::OP_FEST: begin
               case (cmd.axis)
                  ovpk_pkg::AXIS_X: est_x_ff <= r_sat;
                  ovpk_pkg::AXIS_Y: est_y_ff <= r_sat;
                  default:          est_h_ff <= wrap_head(r35[18:0]);
               endcase
            end
            ovpk_pkg::OP_LOAD: begin
               est_x_ff <= req_ff.vis_x;
               est_y_ff <= req_ff.vis_y;
               est_h_ff <= wrap_head(19'(req_ff.vis_heading));
            end
            default: begin
            end
         endcase
      end
   end

   assign stat.func     = req_ff.func;
   assign stat.sum_zero = (sum_ff == '0);
   assign stat.div_busy = div_busy;
   assign rsp_data      = rsp_ff;

endmodule

// ===== hdl/ovpk_ctrl.sv =====
// ----------------------------------------------------------------------------
// ovpk_ctrl
// Sequencer of the pose filter: accepts a beat, steps the datapath through the
// odometry update and the per-axis fusion or load, and holds the result valid.
// ----------------------------------------------------------------------------
module ovpk_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ovpk_pkg::stat_type stat,
   output ovpk_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_STEP,
      ST_SQ,
      ST_NHI,
      ST_NLO,
      ST_NSUM,
      ST_NVAR,
      ST_FPREP,
      ST_FCHK,
      ST_FMUL1,
      ST_FDIV1,
      ST_FWAIT1,
      ST_FEST,
      ST_FMUL2,
      ST_FDIV2,
      ST_FWAIT2,
      ST_FVAR,
      ST_LOAD,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   ovpk_pkg::axis_type axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = ovpk_pkg::OP_IDLE;
      cmd.axis     = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = ovpk_pkg::OP_CAP;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.op   = ovpk_pkg::OP_STEP;
            axis_in  = ovpk_pkg::AXIS_X;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op   = ovpk_pkg::OP_SQ;
            state_in = ST_NHI;
         end
         ST_NHI: begin
            cmd.op   = ovpk_pkg::OP_NHI;
            state_in = ST_NLO;
         end
         ST_NLO: begin
            cmd.op   = ovpk_pkg::OP_NLO;
            state_in = ST_NSUM;
         end
         ST_NSUM: begin
            cmd.op   = ovpk_pkg::OP_NSUM;
            state_in = ST_NVAR;
         end
         ST_NVAR: begin
            cmd.op = ovpk_pkg::OP_NVAR;
            if (axis_ff == ovpk_pkg::AXIS_H) begin
               axis_in = ovpk_pkg::AXIS_X;
               if (stat.func == ovpk_pkg::FUNC_FUSE) begin
                  state_in = ST_FPREP;
               end else if (stat.func == ovpk_pkg::FUNC_LOAD) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               axis_in  = (axis_ff == ovpk_pkg::AXIS_X) ? ovpk_pkg::AXIS_Y : ovpk_pkg::AXIS_H;
               state_in = ST_SQ;
            end
         end
         ST_FPREP: begin
            cmd.op   = ovpk_pkg::OP_FPREP;
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            // A zero variance sum leaves this axis untouched.
            if (stat.sum_zero) begin
               if (axis_ff == ovpk_pkg::AXIS_H) begin
                  state_in = ST_OUT;
               end else begin
                  axis_in  = (axis_ff == ovpk_pkg::AXIS_X) ? ovpk_pkg::AXIS_Y
                                                           : ovpk_pkg::AXIS_H;
                  state_in = ST_FPREP;
               end
            end else begin
               state_in = ST_FMUL1;
            end
         end
         ST_FMUL1: begin
            cmd.op   = ovpk_pkg::OP_FMUL1;
            state_in = ST_FDIV1;
         end
         ST_FDIV1: begin
            cmd.op   = ovpk_pkg::OP_FDIV1;
            state_in = ST_FWAIT1;
         end
         ST_FWAIT1: begin
            if (!stat.div_busy) begin
               state_in = ST_FEST;
            end
         end
         ST_FEST: begin
            cmd.op   = ovpk_pkg::OP_FEST;
            state_in = ST_FMUL2;
         end
         ST_FMUL2: begin
            cmd.op   = ovpk_pkg::OP_FMUL2;
            state_in = ST_FDIV2;
         end
         ST_FDIV2: begin
            cmd.op   = ovpk_pkg::OP_FDIV2;
            state_in = ST_FWAIT2;
         end
         ST_FWAIT2: begin
            if (!stat.div_busy) begin
               state_in = ST_FVAR;
            end
         end
         ST_FVAR: begin
            cmd.op = ovpk_pkg::OP_FVAR;
            if (axis_ff == ovpk_pkg::AXIS_H) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = (axis_ff == ovpk_pkg::AXIS_X) ? ovpk_pkg::AXIS_Y : ovpk_pkg::AXIS_H;
               state_in = ST_FPREP;
            end
         end
         ST_LOAD: begin
            cmd.op   = ovpk_pkg::OP_LOAD;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = ovpk_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= ovpk_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a beat but stayed ready");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) |=> (rsp_valid && req_ready))
      else $error("result not presented after completion");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEST || state_ff == ST_FVAR) |-> !stat.div_busy)
      else $error("quotient used while divider busy");

endmodule

// ===== tb/sv/pose_fusion_checker.sv =====
// ----------------------------------------------------------------------------
// pose_fusion_checker
// Watches the request and result channels and the register port of the pose
// fusion filter, keeps its own copy of the filter state, predicts the pose and
// variances for every accepted request beat and compares each result beat.
// ----------------------------------------------------------------------------
module pose_fusion_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ovpk_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ovpk_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output int                fail_count,
   output int                pending_count
);

   ovpk_pkg::cfg_type cfg;
   logic signed [31:0] pos_x, pos_y;
   logic signed [15:0] heading;
   logic [31:0] vx_q, vy_q, vh_q;
   ovpk_pkg::rsp_type pose_queue[$];

   function automatic longint wrap_angle(longint v);
      longint m;
      m = (v + ovpk_pkg::HEAD_PI) % ovpk_pkg::HEAD_2PI;
      if (m < 0) m += ovpk_pkg::HEAD_2PI;
      return m - ovpk_pkg::HEAD_PI;
   endfunction

   function automatic logic [31:0] clamp_u32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic longint clamp_s32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [31:0] position_noise(longint d);
      logic [63:0] s, sq, hi, lo;
      s = magnitude(d);
      if (s < cfg.min_pos_step) s = cfg.min_pos_step;
      sq = s * s;
      hi = sq >> 32;
      lo = sq & 64'hFFFF_FFFF;
      return clamp_u32(((hi * cfg.noise_gain) << 8) + ((lo * cfg.noise_gain) >> 24));
   endfunction

   function automatic logic [31:0] heading_noise(longint d);
      logic [63:0] s;
      s = magnitude(d);
      if (s < cfg.min_heading_step) s = cfg.min_heading_step;
      return clamp_u32((s * s * cfg.noise_gain) >> 34);
   endfunction

   // Gain-weighted step toward the measurement, magnitude rounded half away.
   function automatic longint blend_toward(longint e, longint m, logic [63:0] v1,
                                           logic [63:0] sum);
      longint diff;
      logic [63:0] q;
      diff = m - e;
      q = (magnitude(diff) * v1 + sum / 2) / sum;
      return diff < 0 ? e - longint'(q) : e + longint'(q);
   endfunction

   function automatic logic [31:0] merged_var(logic [63:0] v1, logic [63:0] v2);
      logic [63:0] sum;
      sum = v1 + v2;
      return 32'((v1 * v2 + sum / 2) / sum);
   endfunction

   task automatic advance_pose(input ovpk_pkg::req_type r, output ovpk_pkg::rsp_type p);
      logic [63:0] sum;
      longint e, m;
      vx_q = clamp_u32(64'(vx_q) + position_noise(longint'(r.delta_x)));
      vy_q = clamp_u32(64'(vy_q) + position_noise(longint'(r.delta_y)));
      vh_q = clamp_u32(64'(vh_q) + heading_noise(longint'(r.delta_heading)));
      pos_x = clamp_s32(longint'(pos_x) + r.delta_x);
      pos_y = clamp_s32(longint'(pos_y) + r.delta_y);
      heading = wrap_angle(longint'(heading) + r.delta_heading);
      if (r.func == ovpk_pkg::FUNC_FUSE) begin
         sum = 64'(vx_q) + r.meas_var_x;
         if (sum != 0) begin
            pos_x = clamp_s32(blend_toward(pos_x, r.vis_x, vx_q, sum));
            vx_q = merged_var(vx_q, r.meas_var_x);
         end
         sum = 64'(vy_q) + r.meas_var_y;
         if (sum != 0) begin
            pos_y = clamp_s32(blend_toward(pos_y, r.vis_y, vy_q, sum));
            vy_q = merged_var(vy_q, r.meas_var_y);
         end
         sum = 64'(vh_q) + r.meas_var_heading;
         if (sum != 0) begin
            e = heading;
            m = wrap_angle(longint'(r.vis_heading));
            if (e - m > ovpk_pkg::HEAD_PI) m += ovpk_pkg::HEAD_2PI;
            else if (m - e > ovpk_pkg::HEAD_PI) e += ovpk_pkg::HEAD_2PI;
            heading = wrap_angle(blend_toward(e, m, vh_q, sum));
            vh_q = merged_var(vh_q, r.meas_var_heading);
         end
      end else if (r.func == ovpk_pkg::FUNC_LOAD) begin
         pos_x = r.vis_x;
         pos_y = r.vis_y;
         heading = wrap_angle(longint'(r.vis_heading));
      end
      p.pose_x = pos_x;
      p.pose_y = pos_y;
      p.pose_heading = heading;
      p.est_var_x = vx_q;
      p.est_var_y = vy_q;
      p.est_var_heading = vh_q;
   endtask

   always @(posedge clock) begin
      ovpk_pkg::rsp_type p, exp_pose;
      if (reset) begin
         cfg <= {ovpk_pkg::NOISE_GAIN_RESET, ovpk_pkg::MIN_POS_RESET,
                 ovpk_pkg::MIN_HEAD_RESET};
         pos_x = 0;
         pos_y = 0;
         heading = 0;
         vx_q = 0;
         vy_q = 0;
         vh_q = ovpk_pkg::VAR_HEAD_RESET;
         pose_queue.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               ovpk_pkg::REG_NOISE_GAIN: cfg.noise_gain <= pwdata[15:0];
               ovpk_pkg::REG_MIN_POS:    cfg.min_pos_step <= pwdata[15:0];
               ovpk_pkg::REG_MIN_HEAD:   cfg.min_heading_step <= pwdata[13:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_pose(req_data, p);
            pose_queue.push_back(p);
         end
         if (rsp_valid && rsp_ready) begin
            if (pose_queue.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_pose = pose_queue.pop_front();
               if (rsp_data !== exp_pose) begin
                  $display("%0t: result mismatch expected %p actual %p",
                           $time, exp_pose, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= pose_queue.size();
      end
   end
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the pose fusion filter with directed and random request beats,
// random result back-pressure and register settings between phases; the
// checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   ovpk_pkg::req_type req_data;
   ovpk_pkg::rsp_type rsp_data;
   logic psel, penable, pwrite, pready;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;
   int fail_count, pending_count;
   bit stall_hold;

   odometry_vision_pose_kalman_top DUT (.*);

   pose_fusion_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Result side: random stalls, one long hold while the sender keeps offering.
   initial begin
      int n, len;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (stall_hold) begin
            rsp_ready <= 0;
            for (n = 0; n < 3000; n++) @(negedge clock);
            stall_hold = 0;
         end
         if ($urandom_range(0, 30) == 0) begin
            rsp_ready <= 0;
            len = gap_length();
            repeat (len) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 30);
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] v);
      @(negedge clock);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic settle();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   // With no gap, valid stays high and the next beat follows directly.
   task automatic send_beat(input ovpk_pkg::req_type r);
      int gap;
      gap = gap_length();
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_heading();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return $signed($urandom_range(0, ovpk_pkg::HEAD_2PI - 1)) - ovpk_pkg::HEAD_PI;
   endfunction

   function automatic logic [31:0] rand_var();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom();
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, 100000);
      endcase
   endfunction

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed($urandom_range(0, 400000)) - 200000;
      endcase
   endfunction

   function automatic ovpk_pkg::req_type rand_beat();
      ovpk_pkg::req_type r;
      r.func = ($urandom_range(0, 9) == 0) ? 2'd3 : $urandom_range(0, 2);
      r.delta_x = rand_pos();
      r.delta_y = rand_pos();
      r.delta_heading = rand_heading();
      r.vis_x = rand_pos();
      r.vis_y = rand_pos();
      r.vis_heading = rand_heading();
      r.meas_var_x = rand_var();
      r.meas_var_y = rand_var();
      r.meas_var_heading = rand_var();
      return r;
   endfunction

   initial begin
      ovpk_pkg::req_type r;
      int i, phase;
      req_valid = 0; req_data = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      stall_hold = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: zero measurement variances, extremes, wrap, load, unused code.
      r = '0;
      r.func = ovpk_pkg::FUNC_FUSE;
      send_beat(r);
      r.func = 2'd0; r.delta_x = 32'h7FFF_FFFF; r.delta_y = 32'h8000_0000;
      r.delta_heading = 16'sd25735;
      send_beat(r);
      send_beat(r);
      r.func = ovpk_pkg::FUNC_LOAD; r.vis_x = 32'h8000_0000; r.vis_y = 32'h7FFF_FFFF;
      r.vis_heading = 16'sh8000;
      send_beat(r);
      r.func = ovpk_pkg::FUNC_FUSE; r.delta_x = 0; r.delta_y = 0;
      r.delta_heading = 16'sh7FFF;
      r.vis_heading = 16'sd25000; r.meas_var_x = 32'hFFFF_FFFF;
      r.meas_var_y = 1; r.meas_var_heading = 32'hFFFF_FFFF;
      send_beat(r);
      r.vis_heading = -16'sd25000; r.delta_heading = -16'sd25736;
      send_beat(r);
      r.func = 2'd3; r.vis_heading = 16'sh7FFF;
      send_beat(r);
      r.func = ovpk_pkg::FUNC_LOAD;
      send_beat(r);
      r.func = ovpk_pkg::FUNC_FUSE; r.vis_heading = 16'sh8000; r.meas_var_heading = 0;
      send_beat(r);
      settle();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               csr_write(ovpk_pkg::REG_NOISE_GAIN, 32'hFFFF);
               csr_write(ovpk_pkg::REG_MIN_POS, 32'hFFFF);
               csr_write(ovpk_pkg::REG_MIN_HEAD, 32'd8192);
            end
            1: begin
               csr_write(ovpk_pkg::REG_NOISE_GAIN, 0);
               csr_write(ovpk_pkg::REG_MIN_POS, 0);
               csr_write(ovpk_pkg::REG_MIN_HEAD, 0);
            end
            2: begin
               csr_write(ovpk_pkg::REG_NOISE_GAIN, $urandom_range(0, 65535));
               csr_write(ovpk_pkg::REG_MIN_POS, $urandom_range(0, 65535));
               csr_write(ovpk_pkg::REG_MIN_HEAD, 32'h3FFF);
            end
            default: begin
               csr_write(ovpk_pkg::REG_NOISE_GAIN, ovpk_pkg::NOISE_GAIN_RESET);
               csr_write(ovpk_pkg::REG_MIN_POS, ovpk_pkg::MIN_POS_RESET);
               csr_write(ovpk_pkg::REG_MIN_HEAD, ovpk_pkg::MIN_HEAD_RESET);
            end
         endcase
         for (i = 0; i < 150; i++) begin
            if (phase == 1 && i == 20) stall_hold = 1;
            send_beat(rand_beat());
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/ovpk_pkg.sv
hdl/ovpk_div.sv
hdl/ovpk_datapath.sv
hdl/ovpk_ctrl.sv
hdl/odometry_vision_pose_kalman_top.sv
tb/sv/pose_fusion_checker.sv
tb/sv/tb_top.sv
